@@ rtl/ddet_pkg.sv @@
// Shared constants, types and state encoding for the due date cost core.
`timescale 1ns / 1ps

package ddet_pkg;

  // Task store depth and the widths that follow from it
  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths
  localparam int TIME_W = 32;
  localparam int COST_W = 64;
  localparam int PT_W   = 16;
  localparam int PEN_W  = 16;
  localparam int PROD_W = PEN_W + TIME_W;

  // One stored task
  typedef struct packed {
    logic [PT_W-1:0]  ptime;
    logic [PEN_W-1:0] early;
    logic [PEN_W-1:0] late;
  } task_t;

  // Control from the sequencer to the cost pipeline
  typedef struct packed {
    logic              clear;
    logic [TIME_W-1:0] start;
    logic              feed;
  } cu_ctl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_PFX_RD,
    ST_PFX_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/ddet_cost_unit.sv @@
// Pipelined cost accumulator: one task word per cycle, weighted deviation summed.
`timescale 1ns / 1ps

module ddet_cost_unit import ddet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cu_ctl_t           ctl,
  input  task_t             task_word,
  input  logic [TIME_W-1:0] due,
  output logic [COST_W-1:0] cost,
  output logic              busy
);

  logic [TIME_W-1:0] now_r, now_nxt;
  logic [PEN_W-1:0]  ep1_r, lp1_r;
  logic              v1_r, v2_r, v3_r;
  logic [TIME_W-1:0] diff2_r, diff2_nxt;
  logic [PEN_W-1:0]  pen2_r, pen2_nxt;
  logic [PROD_W-1:0] prod3_r;
  logic [COST_W-1:0] acc_r;

  // Stage 1: advance the completion time
  assign now_nxt = now_r + {{(TIME_W-PT_W){1'b0}}, task_word.ptime};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      now_r <= ctl.start;
    end else if (ctl.feed) begin
      now_r <= now_nxt;
    end
    ep1_r <= task_word.early;
    lp1_r <= task_word.late;
  end

  // Stage 2: pick deviation and matching penalty
  always_comb begin
    if (now_r < due) begin
      diff2_nxt = due - now_r;
      pen2_nxt  = ep1_r;
    end else if (now_r > due) begin
      diff2_nxt = now_r - due;
      pen2_nxt  = lp1_r;
    end else begin
      diff2_nxt = '0;
      pen2_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    diff2_r <= diff2_nxt;
    pen2_r  <= pen2_nxt;
    // Stage 3: weight the deviation
    prod3_r <= PROD_W'(pen2_r) * PROD_W'(diff2_r);
  end

  // Stage 4: accumulate
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + {{(COST_W-PROD_W){1'b0}}, prod3_r};
    end
  end

  // Track words in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.feed;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign cost = acc_r;
  assign busy = v1_r | v2_r | v3_r;

endmodule

@@ rtl/due_date_earliness_tardiness_cost_core.sv @@
// Top level: task store, candidate-start sequencer and result register.
// A word without the last-task flag is written straight into the store and ready stays high.
// A last-task word starts evaluation: each pass streams the n stored tasks
// through the single store read port and the shared four-stage cost pipeline.
// Given start: one pass, then result and ready again; search: a pass at start zero, then one
// per fitting prefix. A result still waiting on out_ready holds the final step.
// Synchronous active-low reset clears control, search registers, due date and output valid; the store has none.
`timescale 1ns / 1ps

module due_date_earliness_tardiness_cost_core import ddet_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [TIME_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PT_W-1:0]     in_proc_time,
  input  logic [PEN_W-1:0]    in_early_penalty,
  input  logic [PEN_W-1:0]    in_late_penalty,
  input  logic                in_last_task,
  input  logic                in_mode,
  input  logic [TIME_W-1:0]   in_start_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TIME_W-1:0]   out_best_start,
  output logic [COST_W-1:0]   out_total_cost
);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] due_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [TIME_W-1:0] prefix_r, prefix_nxt;
  logic [TIME_W-1:0] cand_r, cand_nxt;
  logic [TIME_W-1:0] best_start_r, best_start_nxt;
  logic [COST_W-1:0] best_cost_r, best_cost_nxt;
  logic              mode_r, mode_nxt;
  logic              init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] out_start_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_load;

  // Task store and its read port
  task_t             mem [MAX_TASKS];
  task_t             rd_data_r;
  logic              rd_vld_r;
  logic              rd_en, feed;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  task_t             wr_word;

  logic              in_fire;
  logic [TIME_W-1:0] pfx_sum;
  logic              cand_ok;
  logic              pipe_busy;
  logic              cu_busy;
  logic [COST_W-1:0] cu_cost;
  cu_ctl_t           cu_ctl;

  assign in_fire = in_valid & in_ready;
  assign pfx_sum = prefix_r + {{(TIME_W-PT_W){1'b0}}, rd_data_r.ptime};
  assign cand_ok = (pfx_sum <= due_r);
  assign pipe_busy = rd_vld_r | cu_busy;

  assign wr_word.ptime = in_proc_time;
  assign wr_word.early = in_early_penalty;
  assign wr_word.late  = in_late_penalty;

  // Due date register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r <= '0;
    end else if (cfg_wr_en) begin
      due_r <= cfg_wr_data;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= wr_word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= feed;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_last_task) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (idx_r == n_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (init_r) begin
            state_nxt = (mode_r || n_r == '0) ? ST_DONE : ST_PFX_RD;
          end else begin
            state_nxt = (j_r == n_r) ? ST_DONE : ST_PFX_RD;
          end
        end
      end
      ST_PFX_RD: state_nxt = ST_PFX_WAIT;
      ST_PFX_WAIT: begin
        if (cand_ok) begin
          state_nxt = ST_EVAL;
        end else if (j_r + CNT_W'(1) == n_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PFX_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    feed           = 1'b0;
    rd_addr        = idx_r[IDX_W-1:0];
    cu_ctl.clear   = 1'b0;
    cu_ctl.start   = cand_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    prefix_nxt     = prefix_r;
    cand_nxt       = cand_r;
    best_start_nxt = best_start_r;
    best_cost_nxt  = best_cost_r;
    mode_nxt       = mode_r;
    init_nxt       = init_r;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Store the task unless full; drop it otherwise
          if (cnt_r < CNT_W'(MAX_TASKS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_last_task) begin
            n_nxt        = cnt_nxt;
            cnt_nxt      = '0;
            mode_nxt     = in_mode;
            init_nxt     = 1'b1;
            idx_nxt      = '0;
            cand_nxt     = in_mode ? in_start_time : '0;
            cu_ctl.clear = 1'b1;
            cu_ctl.start = cand_nxt;
          end
        end
      end
      ST_EVAL: begin
        // Stream stored tasks into the cost pipeline
        if (idx_r != n_r) begin
          rd_en   = 1'b1;
          feed    = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (init_r) begin
            best_cost_nxt  = cu_cost;
            best_start_nxt = cand_r;
            init_nxt       = 1'b0;
            j_nxt          = '0;
            prefix_nxt     = '0;
          end else if (cu_cost < best_cost_r) begin
            best_cost_nxt  = cu_cost;
            best_start_nxt = cand_r;
          end
        end
      end
      ST_PFX_RD: begin
        rd_en   = 1'b1;
        rd_addr = j_r[IDX_W-1:0];
      end
      ST_PFX_WAIT: begin
        // Extend the prefix sum; launch a candidate when it fits under the due date
        prefix_nxt = pfx_sum;
        j_nxt      = j_r + CNT_W'(1);
        if (cand_ok) begin
          cand_nxt     = due_r - pfx_sum;
          cu_ctl.clear = 1'b1;
          cu_ctl.start = cand_nxt;
          idx_nxt      = '0;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) out_load = 1'b1;
      end
      default: ;
    endcase
    cu_ctl.feed = rd_vld_r;
  end

  // Result register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_start_r <= best_start_r;
      out_cost_r  <= best_cost_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      j_r         <= '0;
      mode_r      <= 1'b0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      mode_r      <= mode_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= '0;
      cand_r       <= '0;
      best_start_r <= '0;
      best_cost_r  <= '0;
    end else begin
      prefix_r     <= prefix_nxt;
      cand_r       <= cand_nxt;
      best_start_r <= best_start_nxt;
      best_cost_r  <= best_cost_nxt;
    end
  end

  ddet_cost_unit u_cost (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cu_ctl),
    .task_word (rd_data_r),
    .due       (due_r),
    .cost      (cu_cost),
    .busy      (cu_busy)
  );

  assign out_valid      = out_valid_r;
  assign out_best_start = out_start_r;
  assign out_total_cost = out_cost_r;

endmodule

@@ rtl/ddet_checker.sv @@
// Port-level checks for the due date cost core, bound to the top level.
`timescale 1ns / 1ps

module ddet_checker import ddet_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last_task,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TIME_W-1:0] out_best_start,
  input logic [COST_W-1:0] out_total_cost
);

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_start)
      && $stable(out_total_cost))
    else $error("stalled result word changed");

  // A word that does not close the sequence is stored and input is ready again in the next cycle
  a_store_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_task |=> in_ready)
    else $error("input not ready after storing a task word");

  // Closing word starts an evaluation that blocks input
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_task |=> !in_ready)
    else $error("input ready right after a last task word");

endmodule

bind due_date_earliness_tardiness_cost_core ddet_checker u_ddet_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_task   (in_last_task),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_best_start (out_best_start),
  .out_total_cost (out_total_cost)
);
